// ----- sv/pms_pkg.sv -----
// Package for the profile measurement store.
// Holds op and status codes, default sizes and shared command/status types.
package pms_pkg;

    localparam int SampleDepthDef  = 1024;
    localparam int ProfileSlotsDef = 16;
    localparam int CapW            = 11;
    localparam int OpW             = 3;
    localparam int StW             = 3;
    localparam int ProfW           = 4;
    localparam int WordW           = 32;

    localparam logic [OpW-1:0] OP_RESET     = 3'd0;
    localparam logic [OpW-1:0] OP_ADD       = 3'd1;
    localparam logic [OpW-1:0] OP_SET_POS   = 3'd2;
    localparam logic [OpW-1:0] OP_CLR_PROF  = 3'd3;
    localparam logic [OpW-1:0] OP_CLR_RANGE = 3'd4;
    localparam logic [OpW-1:0] OP_READ      = 3'd5;

    localparam logic [StW-1:0] ST_OK         = 3'd0;
    localparam logic [StW-1:0] ST_FULL       = 3'd1;
    localparam logic [StW-1:0] ST_FIRST_NZ   = 3'd2;
    localparam logic [StW-1:0] ST_BAD_PROF   = 3'd3;
    localparam logic [StW-1:0] ST_RANGE_LONG = 3'd4;
    localparam logic [StW-1:0] ST_NO_READ    = 3'd5;
    localparam logic [StW-1:0] ST_TABLE_FULL = 3'd6;

    // controller to datapath
    typedef struct packed {
        logic decode;    // latch item, evaluate op
        logic move;      // copy one sample downward
        logic finish;    // commit clear bookkeeping
        logic read_mem;  // read registered sample
    } t_pms_cmd;

    // datapath to controller
    typedef struct packed {
        logic need_move;  // clear frees samples and data must move
        logic need_fin;   // clear without moves still needs commit
        logic is_read;    // successful read pending
        logic move_last;  // last copy of a compaction
    } t_pms_sts;

endpackage

// ----- sv/profile_measurement_store_unit.sv -----
// Profile measurement store: one item per start, one strobed result.
// Result strobe follows decode and evaluation for reset, add, set_position,
// unused ops and failed items; a good read adds a read state, a good clear its
// moves and a finish. A new item is taken in the strobe cycle, none while busy.
// Synchronous active-low reset clears pointers, counts and the controller.
// Results are strobed for one cycle; the receiver cannot stall.
module profile_measurement_store_unit import pms_pkg::*; #(
    parameter int SAMPLE_DEPTH  = SampleDepthDef,
    parameter int PROFILE_SLOTS = ProfileSlotsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_strobe,
    input  logic [OpW-1:0]   i_op,
    input  logic [WordW-1:0] i_sample_time,
    input  logic [WordW-1:0] i_pressure_word,
    input  logic [WordW-1:0] i_temperature_word,
    input  logic [ProfW-1:0] i_profile,
    input  logic [CapW-1:0]  i_range_offset,
    input  logic [CapW-1:0]  i_range_length,
    input  logic [WordW-1:0] i_latitude_word,
    input  logic [WordW-1:0] i_longitude_word,
    output logic [StW-1:0]   o_status,
    output logic [WordW-1:0] o_pressure_out,
    output logic [WordW-1:0] o_temperature_out,
    output logic [WordW-1:0] o_start_time_out,
    output logic [WordW-1:0] o_stop_time_out,
    output logic [WordW-1:0] o_latitude_out,
    output logic [WordW-1:0] o_longitude_out,
    output logic             o_profile_done,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [1:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    t_pms_cmd w_cmd;
    t_pms_sts w_sts;
    logic [CapW-1:0] r_capacity;

    assign pready = 1'b1;
    assign prdata = (paddr == 2'd0) ? 32'(r_capacity) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_capacity <= CapW'(1024);
        else if (psel && penable && pwrite && paddr == 2'd0)
            r_capacity <= pwdata[CapW-1:0];
    end

    pms_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(start), .i_sts(w_sts),
        .o_cmd(w_cmd), .o_busy(busy), .o_strobe(o_strobe)
    );

    pms_datapath #(.SAMPLE_DEPTH(SAMPLE_DEPTH), .PROFILE_SLOTS(PROFILE_SLOTS)) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(w_cmd), .o_sts(w_sts),
        .i_capacity(r_capacity), .i_op(i_op), .i_sample_time(i_sample_time),
        .i_pressure_word(i_pressure_word), .i_temperature_word(i_temperature_word),
        .i_profile(i_profile), .i_range_offset(i_range_offset),
        .i_range_length(i_range_length), .i_latitude_word(i_latitude_word),
        .i_longitude_word(i_longitude_word), .o_status(o_status),
        .o_pressure_out(o_pressure_out), .o_temperature_out(o_temperature_out),
        .o_start_time_out(o_start_time_out), .o_stop_time_out(o_stop_time_out),
        .o_latitude_out(o_latitude_out), .o_longitude_out(o_longitude_out),
        .o_profile_done(o_profile_done)
    );
endmodule

// ----- sv/pms_ctrl.sv -----
// Controller for the profile measurement store.
// Sequences decode, compaction moves and result strobes; uses pms_pkg.
module pms_ctrl import pms_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_start,
    input  t_pms_sts i_sts,
    output t_pms_cmd o_cmd,
    output logic     o_busy,
    output logic     o_strobe
);
    typedef enum logic [2:0] {S_IDLE, S_DEC, S_EVAL, S_MOVE, S_FIN, S_READ} t_state;
    t_state r_state;
    logic   r_strobe;

    always_comb begin
        o_cmd.decode   = (r_state == S_IDLE) && i_start;
        o_cmd.move     = (r_state == S_MOVE);
        o_cmd.finish   = (r_state == S_FIN);
        o_cmd.read_mem = (r_state == S_READ);
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = r_strobe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) r_state <= S_DEC;
                end
                S_DEC: begin
                    r_state <= S_EVAL;
                end
                S_EVAL: begin
                    priority if (i_sts.need_move) r_state <= S_MOVE;
                    else if (i_sts.need_fin) r_state <= S_FIN;
                    else if (i_sts.is_read) r_state <= S_READ;
                    else begin
                        r_state  <= S_IDLE;
                        r_strobe <= 1'b1;
                    end
                end
                S_MOVE: begin
                    if (i_sts.move_last) r_state <= S_FIN;
                end
                S_FIN: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                end
                S_READ: begin
                    r_state  <= S_IDLE;
                    r_strobe <= 1'b1;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> r_state == S_IDLE) else $error("strobe outside idle");
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE && i_start) |=> o_busy) else $error("start not taken");
    a_move_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOVE && i_sts.move_last) |=> r_state == S_FIN)
        else $error("move did not finish");
endmodule

// ----- sv/pms_datapath.sv -----
// Datapath of the profile measurement store: sample memories, profile
// tables, pointers and result registers. Uses pms_pkg.
module pms_datapath import pms_pkg::*; #(
    parameter int SAMPLE_DEPTH  = SampleDepthDef,
    parameter int PROFILE_SLOTS = ProfileSlotsDef
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_pms_cmd         i_cmd,
    output t_pms_sts         o_sts,
    input  logic [CapW-1:0]  i_capacity,
    input  logic [OpW-1:0]   i_op,
    input  logic [WordW-1:0] i_sample_time,
    input  logic [WordW-1:0] i_pressure_word,
    input  logic [WordW-1:0] i_temperature_word,
    input  logic [ProfW-1:0] i_profile,
    input  logic [CapW-1:0]  i_range_offset,
    input  logic [CapW-1:0]  i_range_length,
    input  logic [WordW-1:0] i_latitude_word,
    input  logic [WordW-1:0] i_longitude_word,
    output logic [StW-1:0]   o_status,
    output logic [WordW-1:0] o_pressure_out,
    output logic [WordW-1:0] o_temperature_out,
    output logic [WordW-1:0] o_start_time_out,
    output logic [WordW-1:0] o_stop_time_out,
    output logic [WordW-1:0] o_latitude_out,
    output logic [WordW-1:0] o_longitude_out,
    output logic             o_profile_done
);
    localparam int AW = $clog2(SAMPLE_DEPTH);
    localparam int CW = AW + 1;
    localparam int PW = (PROFILE_SLOTS > 1) ? $clog2(PROFILE_SLOTS) : 1;
    localparam int XW = (CW > CapW) ? CW + 1 : CapW + 1;
    localparam logic [XW-1:0] DepthX = XW'(SAMPLE_DEPTH);
    localparam logic [XW-1:0] LastSlot = XW'(PROFILE_SLOTS - 1);

    logic [WordW-1:0] r_pmem [SAMPLE_DEPTH];
    logic [WordW-1:0] r_tmem [SAMPLE_DEPTH];
    logic [CW-1:0]    r_base [PROFILE_SLOTS];
    logic [CW-1:0]    r_cnt  [PROFILE_SLOTS];
    logic [WordW-1:0] r_tstart [PROFILE_SLOTS];
    logic [WordW-1:0] r_tstop  [PROFILE_SLOTS];
    logic [WordW-1:0] r_lat    [PROFILE_SLOTS];
    logic [WordW-1:0] r_lon    [PROFILE_SLOTS];

    logic [CW-1:0]    r_fill, r_rptr, r_wrun, r_rrun;
    logic [ProfW-1:0] r_cur;

    // latched item
    logic [OpW-1:0]   r_op;
    logic [WordW-1:0] r_t, r_pw, r_tw, r_lat_in, r_lon_in;
    logic [ProfW-1:0] r_prof;
    logic [CapW-1:0]  r_off, r_len;

    // clear bookkeeping
    logic             r_need_move, r_need_fin, r_is_read;
    logic [CW-1:0]    r_src, r_dst, r_moves, r_freed, r_newcnt, r_wdst;
    logic [PW-1:0]    r_cprof;
    logic [WordW-1:0] r_mp, r_mt;
    logic             r_mv_q;

    // evaluation of the latched item
    logic [XW-1:0] x_fill, x_cur, x_prof, x_cap, x_eff, x_cnt, x_abs, x_room, x_freed;
    logic [XW-1:0] x_len, x_sum;
    logic          prof_ok;
    logic [PW-1:0] pidx;
    logic [CW-1:0] p_cnt, p_base;
    logic [StW-1:0] ev_status;

    always_comb begin
        pidx    = PW'(r_prof);
        prof_ok = (XW'(r_prof) < XW'(PROFILE_SLOTS));
        p_cnt   = prof_ok ? r_cnt[pidx] : '0;
        p_base  = prof_ok ? r_base[pidx] : '0;
        x_fill  = XW'(r_fill);
        x_cur   = XW'(r_cur);
        x_prof  = XW'(r_prof);
        x_cap   = XW'(i_capacity);
        x_eff   = (x_cap < DepthX) ? x_cap : DepthX;
        x_cnt   = XW'(p_cnt);
        x_len   = (r_op == OP_CLR_PROF) ? x_cnt : XW'(r_len);
        x_abs   = (r_op == OP_CLR_PROF) ? XW'(p_base) : XW'(p_base) + XW'(r_off);
        x_room  = x_fill - x_abs;
        x_freed = '0;
        if (x_abs < x_fill) x_freed = (x_len < x_room) ? x_len : x_room;
        x_sum   = XW'(r_off) + XW'(r_len);
        ev_status = ST_OK;
        unique case (r_op)
            OP_ADD: begin
                priority if (x_fill == '0 && r_prof != '0) ev_status = ST_FIRST_NZ;
                else if (x_fill >= x_eff) ev_status = ST_FULL;
                else if (x_fill != '0 && x_prof > x_cur && x_cur + 1'b1 >= XW'(PROFILE_SLOTS))
                    ev_status = ST_TABLE_FULL;
                else ev_status = ST_OK;
            end
            OP_CLR_PROF: ev_status = (x_prof > x_cur) ? ST_BAD_PROF : ST_OK;
            OP_CLR_RANGE: begin
                priority if (x_prof > x_cur) ev_status = ST_BAD_PROF;
                else if (x_sum > x_cnt) ev_status = ST_RANGE_LONG;
                else ev_status = ST_OK;
            end
            OP_READ: begin
                priority if (!prof_ok) ev_status = ST_BAD_PROF;
                else if (r_rptr >= r_fill) ev_status = ST_NO_READ;
                else ev_status = ST_OK;
            end
            default: ev_status = ST_OK;
        endcase
    end

    assign o_sts.need_move = r_need_move;
    assign o_sts.need_fin  = r_need_fin;
    assign o_sts.is_read   = r_is_read;
    assign o_sts.move_last = (r_moves == CW'(1));

    logic r_eval;
    logic [CW-1:0] nrrun;
    logic [PW-1:0] ncur;
    logic is_clr;
    logic rd_ok;

    always_comb begin
        is_clr = (r_op == OP_CLR_PROF) || (r_op == OP_CLR_RANGE);
        rd_ok  = (r_op == OP_READ) && (ev_status == ST_OK);
        ncur   = PW'(r_cur + 1'b1);
        nrrun  = r_rrun + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.decode) begin
            r_op <= i_op; r_t <= i_sample_time; r_pw <= i_pressure_word;
            r_tw <= i_temperature_word; r_prof <= i_profile; r_off <= i_range_offset;
            r_len <= i_range_length; r_lat_in <= i_latitude_word;
            r_lon_in <= i_longitude_word;
        end
        if (r_eval) begin
            r_cprof  <= pidx;
            r_freed  <= CW'(x_freed);
            r_dst    <= CW'(x_abs);
            r_src    <= CW'(x_abs + x_freed);
            r_moves  <= CW'(x_fill - x_abs - x_freed);
            r_newcnt <= (r_op == OP_CLR_PROF) ? '0 : CW'(x_cnt - XW'(r_len));
        end
        if (i_cmd.move) begin
            r_mp <= r_pmem[r_src[AW-1:0]];
            r_mt <= r_tmem[r_src[AW-1:0]];
            r_wdst <= r_dst;
            r_src <= r_src + 1'b1;
            r_dst <= r_dst + 1'b1;
            r_moves <= r_moves - 1'b1;
        end
        if (r_mv_q) begin
            r_pmem[r_wdst[AW-1:0]] <= r_mp;
            r_tmem[r_wdst[AW-1:0]] <= r_mt;
        end
        if (r_eval && r_op == OP_ADD && ev_status == ST_OK) begin
            r_pmem[r_fill[AW-1:0]] <= r_pw;
            r_tmem[r_fill[AW-1:0]] <= r_tw;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0; r_rptr <= '0; r_wrun <= '0; r_rrun <= '0; r_cur <= '0;
            r_eval <= 1'b0; r_need_move <= 1'b0; r_need_fin <= 1'b0;
            r_is_read <= 1'b0; o_status <= ST_OK; o_profile_done <= 1'b0;
            o_start_time_out <= '0;
            o_stop_time_out <= '0; o_latitude_out <= '0; o_longitude_out <= '0;
            for (int k = 0; k < PROFILE_SLOTS; k++) r_cnt[k] <= '0;
        end else begin
            r_eval <= i_cmd.decode;
            if (r_eval) begin
                o_status <= ev_status;
                o_start_time_out <= rd_ok ? r_tstart[pidx] : '0;
                o_stop_time_out  <= rd_ok ? r_tstop[pidx] : '0;
                o_latitude_out   <= rd_ok ? r_lat[pidx] : '0;
                o_longitude_out  <= rd_ok ? r_lon[pidx] : '0;
                o_profile_done   <= rd_ok && (nrrun == p_cnt);
                r_need_move <= is_clr && ev_status == ST_OK && x_freed != '0
                               && x_fill != x_abs + x_freed;
                r_need_fin  <= is_clr && ev_status == ST_OK;
                r_is_read   <= rd_ok;
                unique case (r_op)
                    OP_RESET: begin
                        r_fill <= '0; r_rptr <= '0; r_cur <= '0;
                        r_wrun <= '0; r_rrun <= '0;
                    end
                    OP_ADD: begin
                        if (ev_status == ST_OK) begin
                            r_tstop[(x_fill != '0 && x_prof > x_cur) ? ncur
                                    : PW'(r_cur)] <= r_t;
                            if (x_fill == '0) begin
                                r_tstart[PW'(r_cur)] <= r_t;
                                r_base[PW'(r_cur)]   <= '0;
                                r_wrun <= r_wrun + 1'b1;
                                r_cnt[PW'(r_cur)] <= r_wrun + 1'b1;
                            end else if (x_prof > x_cur) begin
                                r_cur <= r_cur + 1'b1;
                                r_base[ncur]   <= r_fill;
                                r_tstart[ncur] <= r_t;
                                r_wrun <= CW'(1);
                                r_cnt[ncur] <= CW'(1);
                            end else begin
                                r_wrun <= r_wrun + 1'b1;
                                r_cnt[PW'(r_cur)] <= r_wrun + 1'b1;
                            end
                            r_fill <= r_fill + 1'b1;
                        end
                    end
                    OP_SET_POS: begin
                        r_lat[PW'(r_cur)] <= r_lat_in;
                        r_lon[PW'(r_cur)] <= r_lon_in;
                    end
                    OP_CLR_PROF, OP_CLR_RANGE: ;
                    OP_READ: begin
                        if (rd_ok) r_rrun <= (nrrun == p_cnt) ? '0 : nrrun;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.move) r_need_move <= 1'b0;
            if (i_cmd.finish) begin
                r_need_fin <= 1'b0;
                r_need_move <= 1'b0;
                r_cnt[r_cprof] <= r_newcnt;
                r_fill <= r_fill - r_freed;
                for (int k = 0; k < PROFILE_SLOTS; k++) begin
                    if (XW'(k) > XW'(r_cprof) && XW'(k) <= XW'(r_cur)
                        && XW'(k) <= LastSlot)
                        r_base[k] <= r_base[k] - r_freed;
                end
            end
            if (i_cmd.read_mem) begin
                r_is_read <= 1'b0;
                r_rptr <= r_rptr + 1'b1;
            end
        end
    end

    // write side of the compaction happens in the cycle after its read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_mv_q <= 1'b0;
        else r_mv_q <= i_cmd.move;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pressure_out    <= '0;
            o_temperature_out <= '0;
        end else if (r_eval) begin
            o_pressure_out    <= '0;
            o_temperature_out <= '0;
        end else if (i_cmd.read_mem) begin
            o_pressure_out    <= r_pmem[r_rptr[AW-1:0]];
            o_temperature_out <= r_tmem[r_rptr[AW-1:0]];
        end
    end

    a_fill_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        XW'(r_fill) <= DepthX) else $error("fill past depth");
    a_move_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.move |-> r_src > r_dst) else $error("move direction");
    a_read_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.read_mem |=> r_rptr == $past(r_rptr) + 1'b1) else $error("read pointer");
endmodule

// ----- verif/tb_profile_measurement_store_unit.sv -----
// Testbench for profile_measurement_store_unit: directed and random command items
// checked against an in-bench model of the sample store and profile tables.
// Depends on pms_pkg and the profile_measurement_store_unit RTL only.
module tb_profile_measurement_store_unit;
    import pms_pkg::*;

    localparam logic [OpW-1:0] OP_SPARE_6 = 3'd6;
    localparam logic [OpW-1:0] OP_SPARE_7 = 3'd7;
    localparam logic [1:0]     REG_CAPACITY = 2'd0;
    localparam int             DEPTH = 1024;
    localparam int             SLOTS = 16;

    typedef struct {
        logic [OpW-1:0]   op;
        logic [WordW-1:0] stamp, pres, temp, lat, lon;
        logic [ProfW-1:0] prof;
        logic [CapW-1:0]  off, len;
    } cmd_t;

    typedef struct packed {
        logic [StW-1:0]   status;
        logic [WordW-1:0] pres, temp, t_start, t_stop, lat, lon;
        logic             done;
    } reply_t;

    class store_scoreboard;
        logic [WordW-1:0] pres_mem[DEPTH], temp_mem[DEPTH];
        logic [CapW-1:0]  fill, rd_ptr, wr_run, rd_run, capacity;
        logic [ProfW-1:0] cur;
        logic [CapW-1:0]  base[SLOTS], cnt[SLOTS];
        logic [WordW-1:0] t_start[SLOTS], t_stop[SLOTS], lat[SLOTS], lon[SLOTS];
        bit               has_start[SLOTS], has_stop[SLOTS], has_pos[SLOTS];
        reply_t           replies[$];
        int               mismatches;

        function new();
            capacity = 11'd1024;
            fill = 0; rd_ptr = 0; wr_run = 0; rd_run = 0; cur = 0;
            mismatches = 0;
            for (int i = 0; i < SLOTS; i++) begin
                cnt[i] = 0;
                has_start[i] = 0; has_stop[i] = 0; has_pos[i] = 0;
            end
        endfunction

        function bit readable(int p);
            return rd_ptr >= fill || (has_start[p] && has_stop[p] && has_pos[p]);
        endfunction

        function void free_span(int p, int first, int n);
            int freed;
            freed = 0;
            if (first < fill) freed = (n < fill - first) ? n : fill - first;
            if (freed != 0) begin
                for (int i = 0; i < fill - first - freed; i++) begin
                    pres_mem[first + i] = pres_mem[first + freed + i];
                    temp_mem[first + i] = temp_mem[first + freed + i];
                end
                fill = fill - freed;
                for (int i = p + 1; i <= cur && i < SLOTS; i++)
                    base[i] = base[i] - freed[CapW-1:0];
            end
        endfunction

        function void note(cmd_t c);
            reply_t r;
            int     ecap;
            r = '{default: '0};
            r.status = ST_OK;
            ecap = capacity < DEPTH ? capacity : DEPTH;
            case (c.op)
                OP_RESET: begin
                    fill = 0; rd_ptr = 0; cur = 0; wr_run = 0; rd_run = 0;
                end
                OP_ADD: begin
                    if (fill == 0 && c.prof != 0) r.status = ST_FIRST_NZ;
                    else if (fill >= ecap) r.status = ST_FULL;
                    else if (fill != 0 && c.prof > cur && cur + 1 >= SLOTS)
                        r.status = ST_TABLE_FULL;
                    else begin
                        if (fill == 0) begin
                            t_start[cur] = c.stamp; has_start[cur] = 1; base[cur] = 0;
                        end else if (c.prof > cur) begin
                            cur++;
                            base[cur] = fill;
                            t_start[cur] = c.stamp; has_start[cur] = 1;
                            wr_run = 0;
                        end
                        pres_mem[fill] = c.pres;
                        temp_mem[fill] = c.temp;
                        t_stop[cur] = c.stamp; has_stop[cur] = 1;
                        wr_run++;
                        fill++;
                        cnt[cur] = wr_run;
                    end
                end
                OP_SET_POS: begin
                    lat[cur] = c.lat; lon[cur] = c.lon; has_pos[cur] = 1;
                end
                OP_CLR_PROF: begin
                    if (c.prof > cur) r.status = ST_BAD_PROF;
                    else begin
                        if (cnt[c.prof] != 0) free_span(c.prof, base[c.prof], cnt[c.prof]);
                        cnt[c.prof] = 0;
                    end
                end
                OP_CLR_RANGE: begin
                    if (c.prof > cur) r.status = ST_BAD_PROF;
                    else if (int'(c.off) + int'(c.len) > int'(cnt[c.prof]))
                        r.status = ST_RANGE_LONG;
                    else begin
                        if (c.len != 0)
                            free_span(c.prof, base[c.prof] + c.off, c.len);
                        cnt[c.prof] = cnt[c.prof] - c.len;
                    end
                end
                OP_READ: begin
                    if (rd_ptr >= fill) r.status = ST_NO_READ;
                    else begin
                        r.pres = pres_mem[rd_ptr];
                        r.temp = temp_mem[rd_ptr];
                        r.t_start = t_start[c.prof];
                        r.t_stop = t_stop[c.prof];
                        r.lat = lat[c.prof];
                        r.lon = lon[c.prof];
                        rd_ptr++;
                        rd_run++;
                        if (rd_run == cnt[c.prof]) begin
                            r.done = 1;
                            rd_run = 0;
                        end
                    end
                end
                default: ;
            endcase
            replies.push_back(r);
        endfunction

        function void check(reply_t got);
            reply_t want;
            if (replies.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result, status %0d", got.status);
                return;
            end
            want = replies.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("mismatch exp: st=%0d p=%h t=%h ts=%h tp=%h la=%h lo=%h d=%b",
                        want.status, want.pres, want.temp, want.t_start, want.t_stop,
                        want.lat, want.lon, want.done);
                    $display("         got: st=%0d p=%h t=%h ts=%h tp=%h la=%h lo=%h d=%b",
                        got.status, got.pres, got.temp, got.t_start, got.t_stop,
                        got.lat, got.lon, got.done);
                end
            end
        endfunction
    endclass

    logic             i_clk, i_rst_n, start, busy, o_strobe;
    logic [OpW-1:0]   i_op;
    logic [WordW-1:0] i_sample_time, i_pressure_word, i_temperature_word;
    logic [ProfW-1:0] i_profile;
    logic [CapW-1:0]  i_range_offset, i_range_length;
    logic [WordW-1:0] i_latitude_word, i_longitude_word;
    logic [StW-1:0]   o_status;
    logic [WordW-1:0] o_pressure_out, o_temperature_out, o_start_time_out;
    logic [WordW-1:0] o_stop_time_out, o_latitude_out, o_longitude_out;
    logic             o_profile_done;
    logic             psel, penable, pwrite, pready;
    logic [1:0]       paddr;
    logic [31:0]      pwdata, prdata;

    store_scoreboard sb;
    int              burst_left;

    profile_measurement_store_unit dut (.*);

    initial i_clk = 0;
    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check('{o_status, o_pressure_out, o_temperature_out, o_start_time_out,
                       o_stop_time_out, o_latitude_out, o_longitude_out, o_profile_done});
    end

    task automatic send_item(cmd_t c);
        start <= 1'b1;
        i_op <= c.op; i_sample_time <= c.stamp; i_pressure_word <= c.pres;
        i_temperature_word <= c.temp; i_profile <= c.prof;
        i_range_offset <= c.off; i_range_length <= c.len;
        i_latitude_word <= c.lat; i_longitude_word <= c.lon;
        do @(posedge i_clk); while (busy);
        sb.note(c);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.replies.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CapW-1:0] value);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= REG_CAPACITY; pwdata <= 32'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        sb.capacity = value;
        @(posedge i_clk);
    endtask

    function automatic cmd_t make_cmd(logic [OpW-1:0] op, int prof, int off = 0,
                                      int len = 0);
        cmd_t c;
        c = '{op: op, stamp: $urandom, pres: $urandom, temp: $urandom, lat: $urandom,
              lon: $urandom, prof: prof[ProfW-1:0], off: off[CapW-1:0], len: len[CapW-1:0]};
        return c;
    endfunction

    function automatic cmd_t rand_cmd();
        cmd_t c;
        int   k, r, p, n, o;
        k = $urandom_range(0, 99);
        r = $urandom_range(0, 99);
        p = (r < 80) ? $urandom_range(0, sb.cur) : $urandom_range(0, SLOTS - 1);
        if (k < 40) begin
            if (r < 45) p = sb.cur;
            else if (r < 85) p = (sb.cur < SLOTS - 1) ? sb.cur + 1 : sb.cur;
            else p = $urandom_range(0, SLOTS - 1);
            c = make_cmd(OP_ADD, p);
        end else if (k < 66) begin
            if (!sb.readable(p)) begin
                p = -1;
                for (int i = 0; i < SLOTS; i++) if (p < 0 && sb.readable(i)) p = i;
            end
            c = (p < 0) ? make_cmd(OP_SET_POS, 0) : make_cmd(OP_READ, p);
        end else if (k < 74) begin
            c = make_cmd(OP_SET_POS, $urandom_range(0, SLOTS - 1));
        end else if (k < 84) begin
            n = sb.cnt[p];
            if (r < 20) c = make_cmd(OP_CLR_RANGE, p, $urandom_range(0, 1024),
                                     $urandom_range(0, 1024));
            else begin
                o = $urandom_range(0, n);
                c = make_cmd(OP_CLR_RANGE, p, o, $urandom_range(0, n - o));
            end
        end else if (k < 96) begin
            c = make_cmd(OP_CLR_PROF, p);
        end else if (k < 97) begin
            c = make_cmd(OP_RESET, p);
        end else begin
            c = make_cmd(r < 50 ? OP_SPARE_6 : OP_SPARE_7, p);
        end
        return c;
    endfunction

    task automatic send_with_gaps(cmd_t c);
        if (burst_left == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
        end
        burst_left--;
        send_item(c);
    endtask

    initial begin
        #40_000_000;
        $display("profile_measurement_store_unit verification failed");
        $finish;
    end

    initial begin
        logic [CapW-1:0] caps[8];
        cmd_t            c;
        sb = new();
        burst_left = 0;
        caps = '{11'd1024, 11'd1, 11'd5, 11'd2047, 11'd0, 11'd40, 11'd300, 11'd1024};
        i_rst_n <= 1'b0; start <= 1'b0;
        i_op <= OP_RESET; i_sample_time <= '0; i_pressure_word <= '0;
        i_temperature_word <= '0; i_profile <= '0; i_range_offset <= '0;
        i_range_length <= '0; i_latitude_word <= '0; i_longitude_word <= '0;
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_capacity(11'd1024);

        send_item(make_cmd(OP_READ, 0));
        send_item(make_cmd(OP_ADD, 3));
        c = make_cmd(OP_SET_POS, 0); c.lat = '0; c.lon = '1; send_item(c);
        c = make_cmd(OP_ADD, 0); c.stamp = '0; c.pres = '0; c.temp = '1; send_item(c);
        c = make_cmd(OP_ADD, 0); c.stamp = '1; c.pres = '1; c.temp = '0; send_item(c);
        send_item(make_cmd(OP_ADD, 1));
        send_item(make_cmd(OP_ADD, 1));
        c = make_cmd(OP_SET_POS, 0); c.lat = '1; c.lon = '0; send_item(c);
        send_item(make_cmd(OP_ADD, 15));
        send_item(make_cmd(OP_CLR_RANGE, 9, 0, 1));
        send_item(make_cmd(OP_CLR_RANGE, 0, 1024, 1024));
        send_item(make_cmd(OP_CLR_RANGE, 0, 0, 1));
        send_item(make_cmd(OP_READ, 0));
        send_item(make_cmd(OP_READ, 1));
        send_item(make_cmd(OP_CLR_PROF, 7));
        send_item(make_cmd(OP_CLR_PROF, 2));
        send_item(make_cmd(OP_CLR_PROF, 0));
        send_item(make_cmd(OP_SPARE_6, 0));
        send_item(make_cmd(OP_SPARE_7, 15));
        send_item(make_cmd(OP_RESET, 0));
        send_item(make_cmd(OP_ADD, 0));
        send_item(make_cmd(OP_CLR_PROF, 0));
        send_item(make_cmd(OP_READ, 0));

        foreach (caps[ph]) begin
            drain();
            write_capacity(caps[ph]);
            for (int n = 0; n < 215; n++) begin
                if (ph == 2 && n == 100) drain();
                send_with_gaps(rand_cmd());
            end
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.replies.size() == 0)
            $display("profile_measurement_store_unit verification clean");
        else
            $display("profile_measurement_store_unit verification failed");
        $finish;
    end
endmodule
